// File: rtl/tsot_pkg.sv
// ----------------------------------------------------------------------------
// TCP sequence offset tracker package
// Command codes, close phase codes and the layout of one port table entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsot_pkg;

    // Item commands.
    localparam logic [1:0] CMD_OUTGOING = 2'd0;
    localparam logic [1:0] CMD_INCOMING = 2'd1;
    localparam logic [1:0] CMD_INSERT   = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    // Close phases of a tracked connection.
    localparam logic [2:0] PH_ESTABLISHED = 3'd0;
    localparam logic [2:0] PH_FIN_SENT    = 3'd1;
    localparam logic [2:0] PH_FIN_WAIT_2  = 3'd2;
    localparam logic [2:0] PH_CLOSING     = 3'd3;
    localparam logic [2:0] PH_CLOSE_WAIT  = 3'd4;
    localparam logic [2:0] PH_LAST_ACK    = 3'd5;

    // Reset value of the inserted length register.
    localparam logic [7:0] INSERTED_LENGTH_RESET = 8'd70;

    // One port table entry.
    typedef struct packed {
        logic        valid;
        logic [2:0]  phase;
        logic [31:0] bytes;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// File: rtl/tsot_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read; the read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsot_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; a read at the written address returns old data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tcp_sequence_offset_tracker.sv
// ----------------------------------------------------------------------------
// TCP sequence offset tracker
// Keeps a per-port entry (valid, close phase, inserted byte count) in a RAM,
// rewrites sequence and acknowledgment numbers by the count and follows the
// close handshake of each connection.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+----------------------------------
//  config   | i_cfg_we                    | i_cfg_data (inserted length)
//  input    | i_in_valid / o_in_ready     | command, port, number, four TCP flags
//  output   | o_out_valid / i_out_ready   | adjusted number, found, removed, phase, total
//
// The table read is issued at the accepting edge; the entry is modified in the modify
// stage and written, and the result registered, when that stage advances to the output.
// With the output ready one item per cycle is accepted; the last write is
// forwarded to a read of the same entry that overlapped it.
// After reset all 2^PORT_BITS table entries (65536 at the default) are cleared one entry
// a cycle, with o_in_ready low. A stalled output holds the result and the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_sequence_offset_tracker #(
    parameter int PORT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    // Input items
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_port,
    input  wire logic [31:0] i_seq_number,
    input  wire logic        i_flag_syn,
    input  wire logic        i_flag_ack,
    input  wire logic        i_flag_fin,
    input  wire logic        i_flag_rst,
    // Result items
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_adjusted_number,
    output logic             o_entry_found,
    output logic             o_entry_removed,
    output logic [2:0]       o_phase_after,
    output logic [31:0]      o_added_total
);

    localparam int DEPTH = 1 << PORT_BITS;

    // Configuration register.
    logic [7:0] r_inserted_length;

    // Clearing pass.
    logic                 r_clearing;
    logic [PORT_BITS-1:0] r_clr_idx;

    // Modify stage.
    logic                 r_s1_valid;
    logic [1:0]           r_s1_cmd;
    logic [PORT_BITS-1:0] r_s1_idx;
    logic [31:0]          r_s1_num;
    logic                 r_s1_syn;
    logic                 r_s1_ack;
    logic                 r_s1_fin;
    logic                 r_s1_rst;

    // Last write, forwarded to a read that overlapped it.
    logic                 r_fwd_valid;
    logic [PORT_BITS-1:0] r_fwd_idx;
    tsot_pkg::t_entry     r_fwd_data;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_out_adjusted;
    logic        r_out_found;
    logic        r_out_removed;
    logic [2:0]  r_out_phase;
    logic [31:0] r_out_total;

    // Table RAM signals.
    logic                             ram_we;
    logic [PORT_BITS-1:0]             ram_waddr;
    logic [tsot_pkg::ENTRY_W-1:0]     ram_wdata;
    logic [tsot_pkg::ENTRY_W-1:0]     ram_rdata;

    // Modify stage logic.
    logic             in_accept;
    logic             s1_adv;
    tsot_pkg::t_entry cur;
    tsot_pkg::t_entry n_entry;
    logic             n_removed;
    logic [31:0]      n_adjusted;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_accept  = i_in_valid && o_in_ready;

    // Port table.
    tsot_ram #(
        .WIDTH (tsot_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (i_port[PORT_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    // The clearing pass owns the write port until it finishes.
    assign ram_we    = r_clearing || s1_adv;
    assign ram_waddr = r_clearing ? r_clr_idx : r_s1_idx;
    assign ram_wdata = r_clearing ? '0 : n_entry;

    // Entry update and number rewrite for the item in the modify stage.
    always_comb begin
        cur = (r_fwd_valid && (r_fwd_idx == r_s1_idx)) ? r_fwd_data
                                                       : tsot_pkg::t_entry'(ram_rdata);
        n_entry    = cur;
        n_removed  = 1'b0;
        n_adjusted = '0;
        unique case (r_s1_cmd)
            tsot_pkg::CMD_OUTGOING: begin
                n_adjusted = r_s1_num;
                if (cur.valid) begin
                    if (r_s1_syn) begin
                        n_entry.bytes = '0;
                        n_entry.phase = tsot_pkg::PH_ESTABLISHED;
                    end else if (r_s1_rst) begin
                        n_removed = 1'b1;
                    end else if (r_s1_fin) begin
                        if (cur.phase == tsot_pkg::PH_ESTABLISHED) begin
                            n_entry.phase = tsot_pkg::PH_FIN_SENT;
                        end else if (cur.phase == tsot_pkg::PH_CLOSE_WAIT) begin
                            n_entry.phase = tsot_pkg::PH_LAST_ACK;
                        end
                    end
                    if (!n_removed) begin
                        n_adjusted = r_s1_num + n_entry.bytes;
                    end
                end
            end
            tsot_pkg::CMD_INCOMING: begin
                n_adjusted = r_s1_num;
                if (cur.valid) begin
                    n_adjusted = r_s1_num - cur.bytes;
                    if (r_s1_rst) begin
                        n_removed = 1'b1;
                    end else if (cur.phase == tsot_pkg::PH_FIN_SENT) begin
                        if (r_s1_fin && r_s1_ack) begin
                            n_removed = 1'b1;
                        end else if (r_s1_fin) begin
                            n_entry.phase = tsot_pkg::PH_CLOSING;
                        end else if (r_s1_ack) begin
                            n_entry.phase = tsot_pkg::PH_FIN_WAIT_2;
                        end
                    end else if ((cur.phase == tsot_pkg::PH_CLOSING && r_s1_ack)
                              || (cur.phase == tsot_pkg::PH_LAST_ACK && r_s1_ack)
                              || (cur.phase == tsot_pkg::PH_FIN_WAIT_2 && r_s1_fin)) begin
                        n_removed = 1'b1;
                    end else if (r_s1_fin && cur.phase == tsot_pkg::PH_ESTABLISHED) begin
                        n_entry.phase = tsot_pkg::PH_CLOSE_WAIT;
                    end
                end
            end
            tsot_pkg::CMD_INSERT: begin
                if (cur.valid) begin
                    n_entry.bytes = cur.bytes + {24'd0, r_inserted_length};
                end else begin
                    n_entry.valid = 1'b1;
                    n_entry.phase = tsot_pkg::PH_ESTABLISHED;
                    n_entry.bytes = {24'd0, r_inserted_length};
                end
            end
            tsot_pkg::CMD_NONE: begin
                n_adjusted = '0;
            end
            default: begin
                n_adjusted = '0;
            end
        endcase
        if (n_removed) begin
            n_entry.valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inserted_length <= tsot_pkg::INSERTED_LENGTH_RESET;
            r_clearing        <= 1'b1;
            r_clr_idx         <= '0;
            r_s1_valid        <= 1'b0;
            r_fwd_valid       <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_inserted_length <= i_cfg_data;
            end
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (&r_clr_idx) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_fwd_valid <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= i_command;
            r_s1_idx <= i_port[PORT_BITS-1:0];
            r_s1_num <= i_seq_number;
            r_s1_syn <= i_flag_syn;
            r_s1_ack <= i_flag_ack;
            r_s1_fin <= i_flag_fin;
            r_s1_rst <= i_flag_rst;
        end
        if (s1_adv) begin
            r_fwd_idx      <= r_s1_idx;
            r_fwd_data     <= n_entry;
            r_out_adjusted <= n_adjusted;
            r_out_found    <= cur.valid;
            r_out_removed  <= n_removed;
            r_out_phase    <= n_entry.valid ? n_entry.phase : tsot_pkg::PH_ESTABLISHED;
            r_out_total    <= n_entry.valid ? n_entry.bytes : 32'd0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_adjusted_number = r_out_adjusted;
    assign o_entry_found     = r_out_found;
    assign o_entry_removed   = r_out_removed;
    assign o_phase_after     = r_out_phase;
    assign o_added_total     = r_out_total;

endmodule

`default_nettype wire

// File: rtl/tsot_checker.sv
// ----------------------------------------------------------------------------
// TCP sequence offset tracker checker
// Port-level assertions on the tracker's reset behavior and its results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsot_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_adjusted_number,
    input wire logic        o_entry_found,
    input wire logic        o_entry_removed,
    input wire logic [2:0]  o_phase_after,
    input wire logic [31:0] o_added_total
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_adjusted_number) && $stable(o_added_total))
        else $error("stalled result changed");

    // Reset empties the pipeline and starts the table clearing pass.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block not idle after reset");

    // Only an existing entry can be removed.
    a_remove_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_removed |-> o_entry_found)
        else $error("removed an entry that was not found");

    // A removed entry reports an empty state.
    a_remove_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_removed |->
            o_phase_after == tsot_pkg::PH_ESTABLISHED && o_added_total == 32'd0)
        else $error("removed entry reports state");

    // The close phase stays within its six codes.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_phase_after <= tsot_pkg::PH_LAST_ACK)
        else $error("close phase out of range");

endmodule

bind tcp_sequence_offset_tracker tsot_checker u_tsot_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_adjusted_number (o_adjusted_number),
    .o_entry_found     (o_entry_found),
    .o_entry_removed   (o_entry_removed),
    .o_phase_after     (o_phase_after),
    .o_added_total     (o_added_total)
);

`default_nettype wire
